// ===== hdl/xets_pkg.sv =====
`default_nettype none

package xets_pkg;

    localparam int HOLD_DEPTH_DEF = 16;

    // Kind of text that one accepted item expands into.
    localparam logic [3:0] KIND_PLAIN     = 4'd0;
    localparam logic [3:0] KIND_LT        = 4'd1;
    localparam logic [3:0] KIND_GT        = 4'd2;
    localparam logic [3:0] KIND_AMP       = 4'd3;
    localparam logic [3:0] KIND_APOS      = 4'd4;
    localparam logic [3:0] KIND_QUOT      = 4'd5;
    localparam logic [3:0] KIND_TAG_OPEN  = 4'd6;
    localparam logic [3:0] KIND_TAG_CLOSE = 4'd7;
    localparam logic [3:0] KIND_TERM      = 4'd8;

    localparam logic [8*4-1:0]  STR_LT        = "&lt;";
    localparam logic [8*4-1:0]  STR_GT        = "&gt;";
    localparam logic [8*5-1:0]  STR_AMP       = "&amp;";
    localparam logic [8*6-1:0]  STR_APOS      = "&apos;";
    localparam logic [8*6-1:0]  STR_QUOT      = "&quot;";
    localparam logic [8*13-1:0] STR_TAG_OPEN  = "<replaceable>";
    localparam logic [8*14-1:0] STR_TAG_CLOSE = "</replaceable>";

    typedef struct packed {
        logic accept;
        logic fetch;
        logic pop;
        logic push;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_is_end;
        logic in_is_space;
        logic held_full;
        logic held_empty;
        logic held_one;
        logic item_is_space;
        logic out_free;
        logic text_last;
    } status_t;

    function automatic logic is_space(input logic [7:0] b);
        return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
    endfunction

    function automatic logic [3:0] text_len(input logic [3:0] kind);
        logic [3:0] n;
        case (kind)
            KIND_LT, KIND_GT:     n = 4'd4;
            KIND_AMP:             n = 4'd5;
            KIND_APOS, KIND_QUOT: n = 4'd6;
            KIND_TAG_OPEN:        n = 4'd13;
            KIND_TAG_CLOSE:       n = 4'd14;
            default:              n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] text_char(input logic [3:0] kind, input logic [3:0] idx,
                                             input logic [7:0] plain);
        logic [7:0] ch;
        case (kind)
            KIND_LT:        ch = STR_LT[8*(3-int'(idx)) +: 8];
            KIND_GT:        ch = STR_GT[8*(3-int'(idx)) +: 8];
            KIND_AMP:       ch = STR_AMP[8*(4-int'(idx)) +: 8];
            KIND_APOS:      ch = STR_APOS[8*(5-int'(idx)) +: 8];
            KIND_QUOT:      ch = STR_QUOT[8*(5-int'(idx)) +: 8];
            KIND_TAG_OPEN:  ch = STR_TAG_OPEN[8*(12-int'(idx)) +: 8];
            KIND_TAG_CLOSE: ch = STR_TAG_CLOSE[8*(13-int'(idx)) +: 8];
            KIND_TERM:      ch = 8'h00;
            default:        ch = plain;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/xets_ctrl.sv =====
`default_nettype none

module xets_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire xets_pkg::status_t st,
    output xets_pkg::cmd_t        cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_HOLD  = 3'd3;
    localparam logic [2:0] S_TEXT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    priority if (st.in_is_end)
                        state_next = S_TEXT;
                    else if (st.in_is_space)
                        state_next = st.held_full ? S_FETCH : S_HOLD;
                    else
                        state_next = st.held_empty ? S_TEXT : S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (st.out_free)
                begin
                    cmd.pop = 1'b1;
                    // A full buffer makes room for the new space; otherwise keep flushing.
                    priority if (st.item_is_space)
                        state_next = S_HOLD;
                    else if (st.held_one)
                        state_next = S_TEXT;
                    else
                        state_next = S_FETCH;
                end
            end
            S_HOLD:
            begin
                cmd.push   = 1'b1;
                state_next = S_IDLE;
            end
            S_TEXT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.text_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/xets_dp.sv =====
`default_nettype none

module xets_dp #(
    parameter int HOLD_DEPTH = xets_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              opcode,
    input  wire logic [7:0]        data_byte,
    input  wire xets_pkg::cmd_t    cmd,
    input  wire logic              out_ready,
    output xets_pkg::status_t      st,
    output logic                   out_valid,
    output logic [7:0]             out_byte,
    output logic                   last_of_run,
    output logic                   string_end
);

    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C  = CW'(HOLD_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(HOLD_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HOLD_DEPTH - 1);

    logic            markup_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   head_reg;
    logic [7:0]      byte_reg;
    logic            item_space_reg;
    logic [3:0]      kind_reg;
    logic [3:0]      idx_reg;
    logic [7:0]      rd_data_reg;
    logic [7:0]      held_spaces_mem [HOLD_DEPTH];

    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic            out_end_reg;

    logic [3:0]      kind_next;
    logic [SW-1:0]   tail_sum;
    logic [AW-1:0]   tail_idx;
    logic            out_free;
    logic            text_last;

    // Map the incoming item onto the text it expands into.
    always_comb
    begin
        if (opcode)
            kind_next = xets_pkg::KIND_TERM;
        else
        begin
            case (data_byte)
                8'h3C:   kind_next = markup_reg ? xets_pkg::KIND_TAG_OPEN : xets_pkg::KIND_LT;
                8'h3E:   kind_next = markup_reg ? xets_pkg::KIND_TAG_CLOSE : xets_pkg::KIND_GT;
                8'h26:   kind_next = xets_pkg::KIND_AMP;
                8'h27:   kind_next = xets_pkg::KIND_APOS;
                8'h22:   kind_next = xets_pkg::KIND_QUOT;
                default: kind_next = xets_pkg::KIND_PLAIN;
            endcase
        end
    end

    // Ring slot after the newest held byte; head plus count stays below twice the depth.
    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= DEPTH_S)
            tail_sum = tail_sum - DEPTH_S;
        tail_idx = tail_sum[AW-1:0];
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign text_last = (idx_reg == (xets_pkg::text_len(kind_reg) - 4'd1));

    always_comb
    begin
        st.in_is_end     = opcode;
        st.in_is_space   = xets_pkg::is_space(data_byte);
        st.held_full     = (count_reg == DEPTH_C);
        st.held_empty    = (count_reg == '0);
        st.held_one      = (count_reg == CW'(1));
        st.item_is_space = item_space_reg;
        st.out_free      = out_free;
        st.text_last     = text_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            markup_reg     <= 1'b0;
            count_reg      <= '0;
            head_reg       <= '0;
            item_space_reg <= 1'b0;
            kind_reg       <= xets_pkg::KIND_PLAIN;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                markup_reg <= cfg_wdata;

            if (cmd.accept)
            begin
                item_space_reg <= !opcode && xets_pkg::is_space(data_byte);
                kind_reg       <= kind_next;
                idx_reg        <= '0;
                if (opcode)
                begin
                    count_reg <= '0;
                    head_reg  <= '0;
                end
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CW'(1);
                head_reg  <= (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
            end
            else if (cmd.push)
                count_reg <= count_reg + CW'(1);
            else if (cmd.emit)
                idx_reg <= idx_reg + 4'd1;

            if (cmd.pop || cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            byte_reg <= data_byte;

        if (cmd.pop)
        begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= item_space_reg;
            out_end_reg  <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_byte_reg <= xets_pkg::text_char(kind_reg, idx_reg, byte_reg);
            out_last_reg <= text_last;
            out_end_reg  <= (kind_reg == xets_pkg::KIND_TERM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            held_spaces_mem[tail_idx] <= byte_reg;
        if (cmd.fetch)
            rd_data_reg <= held_spaces_mem[head_reg];
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign string_end  = out_end_reg;

endmodule

`default_nettype wire

// ===== hdl/xml_escape_trim_stream_core.sv =====
// An accepted item goes from the idle state to the text state, which loads its result bytes
// into the output register in turn, up to 14 for an escape; held spaces flushed ahead of it
// pass the fetch state (memory read), then the pop state (output load). A held space goes
// from idle to the hold state. A new item is taken only in the idle state.
// The output register lets the next item enter while the last result waits to be taken.
// Reset (rst_n, asynchronous, active low) empties the hold buffer, clears markup mode
// and the output; the space memory itself is not cleared and needs no clearing pass.
`default_nettype none

module xml_escape_trim_stream_core #(
    parameter int HOLD_DEPTH = xets_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       opcode,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            string_end
);

    xets_pkg::cmd_t    cmd;
    xets_pkg::status_t st;

    xets_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    xets_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .out_ready   (out_ready),
        .st          (st),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .string_end  (string_end)
    );

    // The terminator is always a zero byte and closes its item's run.
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> last_of_run && (out_byte == 8'h00))
        else $error("terminator without last_of_run or with nonzero byte");

    // The buffer is never popped while empty.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !st.held_empty)
        else $error("pop from empty hold buffer");

    // An end beat discards all held whitespace.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode |=> st.held_empty)
        else $error("held whitespace survived an end beat");

    // A result is loaded only into a free output slot.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.pop) |-> (!out_valid || out_ready))
        else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int HOLD         = xets_pkg::HOLD_DEPTH_DEF;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_STALL   = 400;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_flag;
        logic       end_flag;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       opcode = OP_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_end;

    item_t pending_items[$];
    beat_t expected_beats[$];
    item_t next_item;
    beat_t want;

    // Shadow of the block's configuration and space hold buffer.
    logic       markup_copy = 1'b0;
    logic [7:0] held_ring [HOLD];
    logic [3:0] held_hd = 4'd0;
    int         held_cnt = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req = 0;
    int stall_ack = 0;
    int stall_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    xml_escape_trim_stream_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .string_end  (string_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic is_white(input logic [7:0] b);
        return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
    endfunction

    function automatic beat_t make_beat(input logic [7:0] ch, input logic end_flag);
        beat_t r;
        r.ch = ch;
        r.last_flag = 1'b0;
        r.end_flag = end_flag;
        return r;
    endfunction

    function automatic logic [7:0] any_white();
        logic [7:0] b;
        case ($urandom_range(5))
            0:       b = 8'h09;
            1:       b = 8'h0A;
            2:       b = 8'h0B;
            3:       b = 8'h0C;
            4:       b = 8'h0D;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

    // Works out every output beat that one accepted input beat causes.
    task automatic predict_escape(input logic op, input logic [7:0] b);
        beat_t      run_q[$];
        beat_t      r;
        string      txt;
        logic [3:0] slot;
        int         i;
        txt = "";
        if (op == OP_END) begin
            held_cnt = 0;
            held_hd = 4'd0;
            run_q.push_back(make_beat(8'h00, 1'b1));
        end else if (is_white(b)) begin
            if (held_cnt >= HOLD) begin
                run_q.push_back(make_beat(held_ring[held_hd], 1'b0));
                held_hd = held_hd + 4'd1;
                held_cnt = held_cnt - 1;
            end
            slot = held_hd + 4'(held_cnt);
            held_ring[slot] = b;
            held_cnt = held_cnt + 1;
        end else begin
            while (held_cnt > 0) begin
                run_q.push_back(make_beat(held_ring[held_hd], 1'b0));
                held_hd = held_hd + 4'd1;
                held_cnt = held_cnt - 1;
            end
            case (b)
                "<":     txt = markup_copy ? "<replaceable>" : "&lt;";
                ">":     txt = markup_copy ? "</replaceable>" : "&gt;";
                "&":     txt = "&amp;";
                "'":     txt = "&apos;";
                "\"":    txt = "&quot;";
                default: run_q.push_back(make_beat(b, 1'b0));
            endcase
            for (i = 0; i < txt.len(); i++)
                run_q.push_back(make_beat(txt[i], 1'b0));
        end
        foreach (run_q[i])
        begin
            r = run_q[i];
            r.last_flag = (i == run_q.size() - 1);
            expected_beats.push_back(r);
        end
    endtask

    task automatic push_item(input logic op, input logic [7:0] b);
        item_t it;
        it.op = op;
        it.data = b;
        pending_items.push_back(it);
    endtask

    // Mostly whole strings with random content, a few stray beats in between.
    task automatic queue_strings(input int n);
        int made;
        int len;
        int i;
        int j;
        int pick;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 10) begin
                push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
                made++;
            end else begin
                len = $urandom_range(24);
                for (i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 30) begin
                        push_item(OP_DATA, any_white());
                        made++;
                    end else if (pick < 45) begin
                        case ($urandom_range(4))
                            0:       push_item(OP_DATA, "<");
                            1:       push_item(OP_DATA, ">");
                            2:       push_item(OP_DATA, "&");
                            3:       push_item(OP_DATA, "'");
                            default: push_item(OP_DATA, "\"");
                        endcase
                        made++;
                    end else if (pick < 49) begin
                        // A long whitespace run, from HOLD - 2 to HOLD + 6 spaces, can overflow the hold buffer.
                        for (j = $urandom_range(HOLD + 6, HOLD - 2); j > 0; j--) begin
                            push_item(OP_DATA, any_white());
                            made++;
                        end
                    end else begin
                        push_item(OP_DATA, 8'($urandom_range(255)));
                        made++;
                    end
                end
                push_item(OP_END, 8'($urandom_range(255)));
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        markup_copy = v;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            opcode <= OP_DATA;
            data_byte <= 8'h00;
        end else begin
            if (in_valid && in_ready)
                predict_escape(opcode, data_byte);
            if (!in_valid || in_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_item.op;
                    data_byte <= next_item.data;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
            stall_ack <= 0;
        end else if (stall_ack != stall_req) begin
            stall_ack <= stall_req;
            stall_left <= LONG_STALL;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: out_byte %h", out_byte);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (out_byte !== want.ch) begin
                    $error("out_byte expected %h actual %h", want.ch, out_byte);
                    fail_count++;
                end
                if (last_of_run !== want.last_flag) begin
                    $error("last_of_run expected %b actual %b", want.last_flag, last_of_run);
                    fail_count++;
                end
                if (string_end !== want.end_flag) begin
                    $error("string_end expected %b actual %b", want.end_flag, string_end);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : main_seq
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        push_item(OP_END, 8'hFF);
        push_item(OP_DATA, 8'h00);
        push_item(OP_DATA, "<");
        push_item(OP_DATA, ">");
        push_item(OP_DATA, "&");
        push_item(OP_DATA, "'");
        push_item(OP_DATA, "\"");
        // One more space than the hold buffer takes.
        for (i = 0; i <= HOLD; i++)
            push_item(OP_DATA, (i % 6 == 5) ? 8'h20 : 8'(8'h09 + i % 6));
        push_item(OP_DATA, 8'hFF);
        push_item(OP_DATA, 8'h20);
        push_item(OP_END, 8'h00);
        wait_idle();

        write_mode(1'b1);
        send_idle_pct = 12;
        recv_idle_pct = 82;
        queue_strings(140);
        wait_idle();

        write_mode(1'b0);
        send_idle_pct = 82;
        recv_idle_pct = 12;
        queue_strings(140);
        wait_idle();

        write_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req = stall_req + 1;
        queue_strings(130);
        wait_idle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
